>>> design/hclp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hclp_pkg: shared constants and helpers of the hex colour line parser
// Character codes, line buffer sizes and hex digit decoding.
// ----------------------------------------------------------------------------
package hclp_pkg;

	localparam int LINE_CAPACITY = 64;
	localparam int KEPT_CHARS    = 7;
	localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
	localparam int KEPT_IDX_W    = $clog2(KEPT_CHARS);
	localparam int REM_W         = 2;

	localparam logic [7:0] ASCII_BS    = 8'd8;
	localparam logic [7:0] ASCII_LF    = 8'd10;
	localparam logic [7:0] ASCII_CR    = 8'd13;
	localparam logic [7:0] ASCII_SPACE = 8'd32;
	localparam logic [7:0] ASCII_HASH  = 8'd35;
	localparam logic [7:0] ASCII_DASH  = 8'd45;
	localparam logic [7:0] ASCII_DEL   = 8'd127;
	localparam logic [7:0] ASCII_0     = 8'd48;
	localparam logic [7:0] ASCII_9     = 8'd57;
	localparam logic [7:0] ASCII_LC_A  = 8'd97;
	localparam logic [7:0] ASCII_LC_F  = 8'd102;
	localparam logic [7:0] CASE_BIT    = 8'd32;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ASCII_0) && (c <= ASCII_9);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		logic [7:0] low;
		low = c | CASE_BIT;
		return is_digit(c) || ((low >= ASCII_LC_A) && (low <= ASCII_LC_F));
	endfunction

	// letters a..f and A..F have low nibbles 1..6
	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		logic [3:0] v;
		if (is_digit(c)) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	function automatic logic [7:0] pair_val(input logic [7:0] hi, input logic [7:0] lo);
		return {hex_nib(hi), hex_nib(lo)};
	endfunction

endpackage : hclp_pkg
`default_nettype wire

>>> design/hclp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hclp_in_if: received byte channel
// Valid/ready channel carrying one received serial character per beat.
// ----------------------------------------------------------------------------
interface hclp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface : hclp_in_if
`default_nettype wire

>>> design/hclp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hclp_out_if: transmit byte channel
// Valid/ready channel carrying one byte to send plus held colour per beat.
// ----------------------------------------------------------------------------
interface hclp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       color_changed;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last;

	modport source (output valid, output tx_byte, output color_changed, output red,
		output green, output blue, output last, input ready);
	modport sink   (input valid, input tx_byte, input color_changed, input red,
		input green, input blue, input last, output ready);
endinterface : hclp_out_if
`default_nettype wire

>>> design/hex_color_line_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_color_line_parser: serial line editor that sets a held RGB colour
// Echoes received bytes, handles backspace and line ends, and takes
// "#rrggbb" lines as the new colour.
// ----------------------------------------------------------------------------
// A received byte is registered, then handled combinationally; its result beats
// leave through a single output register, one beat per cycle unless tx.ready
// stalls them. A byte yields k beats (echo 1, line end 2, backspace 3) or
// none; the next byte is taken while the last beat of the previous one
// still waits in the output register. Each beat carries the held colour
// after its byte was handled; last marks the final beat of a byte.
// ----------------------------------------------------------------------------
module hex_color_line_parser
	import hclp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	hclp_in_if.sink    rx,
	hclp_out_if.source tx
);

	// input stage
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// state
	logic [CNT_W-1:0] char_count_q;
	logic [7:0]       line_q [KEPT_CHARS];
	logic [7:0]       red_q, green_q, blue_q;

	// output head and the beats queued behind it
	logic             out_valid_q;
	logic [7:0]       out_tx_q;
	logic             out_chg_q;
	logic [7:0]       out_red_q, out_green_q, out_blue_q;
	logic             out_last_q;
	logic [REM_W-1:0] rem_cnt_q;
	logic [7:0]       rem_tx_q [2];

	logic out_free;
	logic take_s1;

	// item decode
	logic             is_end, is_bs, color_ok, store_char;
	logic             item_has;
	logic [7:0]       item_tx;
	logic             item_chg, item_last;
	logic [REM_W-1:0] item_rem_cnt;
	logic [7:0]       item_rem0, item_rem1;
	logic [CNT_W-1:0] count_nx;
	logic [7:0]       red_nx, green_nx, blue_nx;
	logic             hex_all;

	assign out_free = !out_valid_q || tx.ready;
	assign take_s1  = valid_s1 && out_free && (rem_cnt_q == '0);
	assign rx.ready = !valid_s1 || take_s1;

	always_comb begin
		hex_all = 1'b1;
		for (int i = 1; i < KEPT_CHARS; i++) begin
			hex_all = hex_all && is_hex(line_q[i]);
		end
	end

	always_comb begin
		is_end = (rx_byte_s1 == ASCII_LF) || (rx_byte_s1 == ASCII_CR)
			|| ((char_count_q == CNT_W'(KEPT_CHARS)) && (rx_byte_s1 == ASCII_DASH));
		is_bs    = (rx_byte_s1 == ASCII_BS) || (rx_byte_s1 == ASCII_DEL);
		color_ok = (char_count_q == CNT_W'(KEPT_CHARS)) && (line_q[0] == ASCII_HASH) && hex_all;

		item_has     = 1'b0;
		item_tx      = rx_byte_s1;
		item_chg     = 1'b0;
		item_last    = 1'b0;
		item_rem_cnt = '0;
		item_rem0    = ASCII_SPACE;
		item_rem1    = ASCII_BS;
		count_nx     = char_count_q;
		red_nx       = red_q;
		green_nx     = green_q;
		blue_nx      = blue_q;
		store_char   = 1'b0;

		priority if (is_end) begin
			item_has     = 1'b1;
			item_tx      = ASCII_CR;
			item_chg     = color_ok;
			item_rem_cnt = REM_W'(1);
			item_rem0    = ASCII_LF;
			count_nx     = '0;
			if (color_ok) begin
				red_nx   = pair_val(line_q[1], line_q[2]);
				green_nx = pair_val(line_q[3], line_q[4]);
				blue_nx  = pair_val(line_q[5], line_q[6]);
			end
		end else if (is_bs) begin
			if (char_count_q != '0) begin
				item_has     = 1'b1;
				item_tx      = ASCII_BS;
				item_rem_cnt = REM_W'(2);
				count_nx     = char_count_q - CNT_W'(1);
			end
		end else if (char_count_q < CNT_W'(LINE_CAPACITY)) begin
			item_has   = 1'b1;
			item_last  = 1'b1;
			store_char = char_count_q < CNT_W'(KEPT_CHARS);
			count_nx   = char_count_q + CNT_W'(1);
		end else begin
			item_has = 1'b0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			char_count_q <= '0;
			red_q        <= '0;
			green_q      <= '0;
			blue_q       <= '0;
			out_valid_q  <= 1'b0;
			rem_cnt_q    <= '0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (out_free) begin
				if (rem_cnt_q != '0) begin
					out_valid_q <= 1'b1;
					rem_cnt_q   <= rem_cnt_q - REM_W'(1);
				end else if (take_s1) begin
					out_valid_q <= item_has;
					rem_cnt_q   <= item_rem_cnt;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
			if (take_s1) begin
				char_count_q <= count_nx;
				red_q        <= red_nx;
				green_q      <= green_nx;
				blue_q       <= blue_nx;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
		if (take_s1 && store_char) begin
			line_q[char_count_q[KEPT_IDX_W-1:0]] <= rx_byte_s1;
		end
		if (out_free) begin
			if (rem_cnt_q != '0) begin
				out_tx_q    <= rem_tx_q[0];
				out_chg_q   <= 1'b0;
				out_last_q  <= (rem_cnt_q == REM_W'(1));
				out_red_q   <= red_q;
				out_green_q <= green_q;
				out_blue_q  <= blue_q;
				rem_tx_q[0] <= rem_tx_q[1];
			end else if (take_s1) begin
				out_tx_q    <= item_tx;
				out_chg_q   <= item_chg;
				out_last_q  <= item_last;
				out_red_q   <= red_nx;
				out_green_q <= green_nx;
				out_blue_q  <= blue_nx;
				rem_tx_q[0] <= item_rem0;
				rem_tx_q[1] <= item_rem1;
			end
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.tx_byte       = out_tx_q;
	assign tx.color_changed = out_chg_q;
	assign tx.red           = out_red_q;
	assign tx.green         = out_green_q;
	assign tx.blue          = out_blue_q;
	assign tx.last          = out_last_q;

	// queued beats always sit behind a valid head
	assert property (@(posedge clk) disable iff (!arst_n)
		(rem_cnt_q != '0) |-> out_valid_q)
		else $error("queued beats without output head");

	assert property (@(posedge clk) disable iff (!arst_n)
		char_count_q <= CNT_W'(LINE_CAPACITY))
		else $error("line count beyond capacity");

	// beats of one byte go out without a gap
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tx.ready && !out_last_q) |=> out_valid_q)
		else $error("gap inside a byte's result beats");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_chg_q) |-> (out_tx_q == ASCII_CR))
		else $error("colour change flagged off a line end");

	// no new byte handled while beats are still queued
	assert property (@(posedge clk) disable iff (!arst_n)
		(rem_cnt_q != '0) |-> !take_s1)
		else $error("byte handled with beats still queued");

endmodule : hex_color_line_parser
`default_nettype wire

>>> tb/sv/hex_color_line_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_color_line_parser_test: self-checking bench for the hex colour parser
// Drives received bytes through the valid/ready input channel, mirrors the
// line editor and colour registers in a local predictor, and compares every
// transmitted beat with the oldest predicted one. Both sides idle at random.
// ----------------------------------------------------------------------------
module hex_color_line_parser_test;
	import hclp_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0] tx_byte;
		logic       color_changed;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} tx_beat_t;

	logic clk;
	logic arst_n;

	hclp_in_if  rx_ch ();
	hclp_out_if tx_ch ();

	hex_color_line_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	// predictor state
	logic [7:0]  line_buf [KEPT_CHARS];
	int unsigned line_len;
	logic [7:0]  held_red, held_green, held_blue;
	tx_beat_t    pending_beats [$];

	int unsigned rx_idle_pct;
	int unsigned tx_stall_pct;
	int unsigned n_sent;
	int unsigned n_errors;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// {valid, value}; valid clear for anything that is not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] folded;
		logic [7:0] v;
		folded = c | CASE_BIT;
		if (c >= ASCII_0 && c <= ASCII_9) begin
			v = c - ASCII_0;
			return {1'b1, v[3:0]};
		end
		if (folded >= ASCII_LC_A && folded <= ASCII_LC_F) begin
			v = folded - ASCII_LC_A + 8'd10;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

	task automatic push_beat(input logic [7:0] b, input logic changed, input logic is_last);
		tx_beat_t beat;
		beat.tx_byte       = b;
		beat.color_changed = changed;
		beat.red           = held_red;
		beat.green         = held_green;
		beat.blue          = held_blue;
		beat.last          = is_last;
		pending_beats.push_back(beat);
	endtask

	task automatic apply_rx_byte(input logic [7:0] c);
		logic       colour_ok;
		logic [4:0] d;
		logic [3:0] nib [KEPT_CHARS];
		if (c == ASCII_CR || c == ASCII_LF || (line_len == KEPT_CHARS && c == ASCII_DASH)) begin
			colour_ok = (line_len == KEPT_CHARS) && (line_buf[0] == ASCII_HASH);
			for (int i = 1; i < KEPT_CHARS; i++) begin
				d = hex_digit(line_buf[i]);
				colour_ok &= d[4];
				nib[i] = d[3:0];
			end
			if (colour_ok) begin
				held_red   = {nib[1], nib[2]};
				held_green = {nib[3], nib[4]};
				held_blue  = {nib[5], nib[6]};
			end
			line_len = 0;
			push_beat(ASCII_CR, colour_ok, 1'b0);
			push_beat(ASCII_LF, 1'b0, 1'b1);
		end else if (c == ASCII_BS || c == ASCII_DEL) begin
			if (line_len != 0) begin
				line_len--;
				push_beat(ASCII_BS, 1'b0, 1'b0);
				push_beat(ASCII_SPACE, 1'b0, 1'b0);
				push_beat(ASCII_BS, 1'b0, 1'b1);
			end
		end else if (line_len < LINE_CAPACITY) begin
			if (line_len < KEPT_CHARS)
				line_buf[line_len] = c;
			line_len++;
			push_beat(c, 1'b0, 1'b1);
		end
	endtask

	task automatic check_beat();
		tx_beat_t want;
		if (pending_beats.size() == 0) begin
			$error("unexpected beat: tx_byte %0d", tx_ch.tx_byte);
			n_errors++;
		end else begin
			want = pending_beats.pop_front();
			if (tx_ch.tx_byte !== want.tx_byte) begin
				$error("tx_byte: expected %0d, got %0d", want.tx_byte, tx_ch.tx_byte);
				n_errors++;
			end
			if (tx_ch.color_changed !== want.color_changed) begin
				$error("color_changed: expected %0d, got %0d", want.color_changed,
					tx_ch.color_changed);
				n_errors++;
			end
			if (tx_ch.red !== want.red) begin
				$error("red: expected %0d, got %0d", want.red, tx_ch.red);
				n_errors++;
			end
			if (tx_ch.green !== want.green) begin
				$error("green: expected %0d, got %0d", want.green, tx_ch.green);
				n_errors++;
			end
			if (tx_ch.blue !== want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, tx_ch.blue);
				n_errors++;
			end
			if (tx_ch.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, tx_ch.last);
				n_errors++;
			end
		end
	endtask

	// outputs checked before the input beat of the same edge is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (tx_ch.valid && tx_ch.ready)
				check_beat();
			if (rx_ch.valid && rx_ch.ready)
				apply_rx_byte(rx_ch.rx_byte);
		end
	end

	always @(posedge clk) begin
		tx_ch.ready <= ($urandom_range(99) >= tx_stall_pct);
	end

	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_rx_byte(input logic [7:0] b);
		while ($urandom_range(99) < rx_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		n_sent++;
	endtask

	task automatic wait_drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// backspace on an empty line, byte extremes, dash away from count 7
	task automatic test_edit_keys();
		send_rx_byte(ASCII_BS);
		send_rx_byte(ASCII_DEL);
		send_rx_byte(8'h00);
		send_rx_byte(8'hFF);
		send_rx_byte(ASCII_DASH);
		send_rx_byte(ASCII_DEL);
		send_rx_byte(ASCII_BS);
		send_rx_byte(ASCII_BS);
	endtask

	// mixed case colour ended by CR, then one ended by a dash
	task automatic test_colour_lines();
		logic [7:0] first [KEPT_CHARS]  = '{"#", "A", "0", "f", "9", "C", "3"};
		logic [7:0] second [KEPT_CHARS] = '{"#", "0", "9", "a", "f", "A", "F"};
		foreach (first[i])
			send_rx_byte(first[i]);
		send_rx_byte(ASCII_CR);
		foreach (second[i])
			send_rx_byte(second[i]);
		send_rx_byte(ASCII_DASH);
	endtask

	// runs past the line capacity so the surplus is dropped
	task automatic test_long_line();
		for (int i = 0; i < LINE_CAPACITY + 4; i++)
			send_rx_byte(8'(ASCII_LC_A + $urandom_range(25)));
		repeat (3) send_rx_byte($urandom_range(1) ? ASCII_BS : ASCII_DEL);
		send_rx_byte(ASCII_CR);
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned first_sent;
		int unsigned kind;
		int unsigned bad_pos;
		int unsigned v;
		logic [7:0]  c;
		first_sent = n_sent;
		while (n_sent - first_sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				// colour line, now and then with one corrupted char or a retyped one
				bad_pos = $urandom_range(27);
				for (int i = 0; i < KEPT_CHARS; i++) begin
					if (i == 0) begin
						c = ASCII_HASH;
					end else begin
						v = $urandom_range(15);
						if (v < 10) begin
							c = 8'(ASCII_0 + v);
						end else begin
							c = 8'(ASCII_LC_A + v - 10);
							if ($urandom_range(1))
								c = c & ~CASE_BIT;
						end
					end
					if (i == bad_pos)
						c = 8'($urandom_range(255));
					send_rx_byte(c);
					if ($urandom_range(9) == 0) begin
						send_rx_byte($urandom_range(1) ? ASCII_BS : ASCII_DEL);
						send_rx_byte(c);
					end
				end
				case ($urandom_range(2))
					0: begin
						send_rx_byte(ASCII_CR);
					end
					1: begin
						send_rx_byte(ASCII_LF);
					end
					default: begin
						send_rx_byte(ASCII_DASH);
					end
				endcase
			end else if (kind < 70) begin
				repeat ($urandom_range(12)) send_rx_byte(8'($urandom_range(32, 126)));
				send_rx_byte($urandom_range(1) ? ASCII_CR : ASCII_LF);
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom_range(255)));
			end else if (kind < 92) begin
				repeat ($urandom_range(1, 3))
					send_rx_byte($urandom_range(1) ? ASCII_BS : ASCII_DEL);
			end else begin
				repeat (KEPT_CHARS) send_rx_byte(8'($urandom_range(32, 126)));
				send_rx_byte(ASCII_DASH);
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'd0;
		tx_ch.ready   = 1'b0;
		rx_idle_pct   = 0;
		tx_stall_pct  = 0;
		n_sent        = 0;
		n_errors      = 0;
		quiet_cycles  = 0;
		line_len      = 0;
		held_red      = 8'd0;
		held_green    = 8'd0;
		held_blue     = 8'd0;
		foreach (line_buf[i])
			line_buf[i] = 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edit_keys();
		test_colour_lines();
		test_long_line();
		test_random_traffic(35);
		rx_idle_pct = 63;
		test_random_traffic(35);
		rx_idle_pct  = 0;
		tx_stall_pct = 63;
		test_random_traffic(35);
		rx_idle_pct  = 32;
		tx_stall_pct = 32;
		test_random_traffic(35);
		wait_drain();

		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule : hex_color_line_parser_test
